// File: design/prfd_pkg.sv
`timescale 1ns / 1ps

package prfd_pkg;

    localparam int PIXELS_PER_RESULT = 4;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_W             = 23;
    localparam int RGB_W             = 24;
    localparam int RUN_W             = 9;
    localparam int CNT_W             = 3;

    localparam logic [CFG_W-1:0] FRAME_PIXELS_RESET = 23'd65536;
    localparam logic [RUN_W-1:0] FULL_RUN           = 9'd256;

    typedef enum logic {
        MODE_PALETTE = 1'b0,
        MODE_RUN     = 1'b1
    } t_mode;

    // one classified item as it waits in the queue
    typedef struct packed {
        t_mode            mode;
        logic [RUN_W-1:0] run_len;
        logic [7:0]       index;
        logic             in_range;
        logic [RGB_W-1:0] color;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: design/prfd_in_if.sv
`timescale 1ns / 1ps

interface prfd_in_if;
    import prfd_pkg::*;

    logic             valid;
    logic             ready;
    logic             mode;
    logic [7:0]       run_length;
    logic [7:0]       color_index;
    logic [RGB_W-1:0] palette_color;

    modport source (
        output valid, mode, run_length, color_index, palette_color,
        input  ready
    );

    modport sink (
        input  valid, mode, run_length, color_index, palette_color,
        output ready
    );
endinterface

// File: design/prfd_out_if.sv
`timescale 1ns / 1ps

interface prfd_out_if;
    import prfd_pkg::*;

    logic             valid;
    logic             ready;
    logic [RGB_W-1:0] pixel_a;
    logic [RGB_W-1:0] pixel_b;
    logic [RGB_W-1:0] pixel_c;
    logic [RGB_W-1:0] pixel_d;
    logic [CNT_W-1:0] valid_count;
    logic             run_done;
    logic             frame_done;

    modport source (
        output valid, pixel_a, pixel_b, pixel_c, pixel_d, valid_count, run_done, frame_done,
        input  ready
    );

    modport sink (
        input  valid, pixel_a, pixel_b, pixel_c, pixel_d, valid_count, run_done, frame_done,
        output ready
    );
endinterface

// File: design/prfd_ram.sv
`timescale 1ns / 1ps

module prfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/prfd_front.sv
`timescale 1ns / 1ps

module prfd_front #(
    parameter int PALETTE_SIZE = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    prfd_in_if.sink        i_item,
    input  logic           i_q_full,
    output logic           o_push,
    output prfd_pkg::t_cmd o_cmd
);
    import prfd_pkg::*;

    localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_SIZE);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic push;
    logic take;
    logic keep;

    // palette writes beyond the palette are dropped here
    assign push = r_valid && !i_q_full;
    assign i_item.ready = !r_valid || push;
    assign take = i_item.valid && i_item.ready;
    assign keep = (i_item.mode == MODE_RUN) || ({1'b0, i_item.color_index} < PAL_LIMIT);

    always_comb begin
        n_valid = r_valid && !push;
        n_cmd = r_cmd;
        if (take) begin
            n_valid          = keep;
            n_cmd.mode       = t_mode'(i_item.mode);
            n_cmd.run_len    = (i_item.run_length == 8'd0) ? FULL_RUN
                                                           : {1'b0, i_item.run_length};
            n_cmd.index      = i_item.color_index;
            n_cmd.in_range   = {1'b0, i_item.color_index} < PAL_LIMIT;
            n_cmd.color      = i_item.palette_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

    assign o_push = push;
    assign o_cmd  = r_cmd;
endmodule

// File: design/prfd_fifo.sv
`timescale 1ns / 1ps

module prfd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  prfd_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output prfd_pkg::t_cmd    o_cmd,
    output prfd_pkg::t_q_stat o_stat
);
    import prfd_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
endmodule

// File: design/prfd_back.sv
`timescale 1ns / 1ps

module prfd_back #(
    parameter int PALETTE_SIZE     = 256,
    parameter int MAX_FRAME_PIXELS = 4194304
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [prfd_pkg::CFG_W-1:0] i_frame_pixels,
    input  prfd_pkg::t_cmd             i_cmd,
    input  prfd_pkg::t_q_stat          i_q_stat,
    output logic                       o_pop,
    prfd_out_if.source                 o_result
);
    import prfd_pkg::*;

    localparam int IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int PD_W  = $clog2(MAX_FRAME_PIXELS);
    localparam int FP_W  = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int W     = (FP_W > CFG_W) ? FP_W : CFG_W;
    localparam logic [W-1:0] MAX_FP = W'(MAX_FRAME_PIXELS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [RUN_W-1:0] r_left;
    logic [RUN_W-1:0] n_left;
    logic             r_in_range;
    logic             n_in_range;
    logic [PD_W-1:0]  r_pd;
    logic [PD_W-1:0]  n_pd;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [RGB_W-1:0] r_pix [PIXELS_PER_RESULT];
    logic [RGB_W-1:0] n_pix [PIXELS_PER_RESULT];
    logic [CNT_W-1:0] r_vcnt;
    logic [CNT_W-1:0] n_vcnt;
    logic             r_run_done;
    logic             n_run_done;
    logic             r_frame_done;
    logic             n_frame_done;

    logic [RGB_W-1:0] rdata;
    logic [RGB_W-1:0] color;
    logic             ram_we;
    logic             ram_re;
    logic [W-1:0]     cfg_ext;
    logic [W-1:0]     eff_fp;
    logic [W-1:0]     pd_ext;
    logic [W-1:0]     diff;
    logic             at_end;
    logic             rem_le4;
    logic [CNT_W-1:0] rem_small;
    logic [CNT_W-1:0] left_small;
    logic [CNT_W-1:0] cnt;
    logic             frame_end;
    logic             out_free;
    logic [RUN_W-1:0] left_next;

    prfd_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PALETTE_SIZE)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_cmd.index[IDX_W-1:0]),
        .i_wdata (i_cmd.color),
        .i_re    (ram_re),
        .i_raddr (i_cmd.index[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    // clamp the frame size into 1..MAX_FRAME_PIXELS
    assign cfg_ext = W'(i_frame_pixels);
    assign eff_fp  = (cfg_ext == '0) ? W'(1) : ((cfg_ext > MAX_FP) ? MAX_FP : cfg_ext);
    assign pd_ext  = W'(r_pd);
    assign diff    = eff_fp - pd_ext;
    assign at_end  = (pd_ext + W'(1)) >= eff_fp;

    // pixels left in the frame, saturated at four
    assign rem_le4   = at_end || (diff <= W'(PIXELS_PER_RESULT));
    assign rem_small = at_end ? CNT_W'(1)
                     : (rem_le4 ? diff[CNT_W-1:0] : CNT_W'(PIXELS_PER_RESULT));
    assign left_small = (r_left >= RUN_W'(PIXELS_PER_RESULT)) ? CNT_W'(PIXELS_PER_RESULT)
                                                             : r_left[CNT_W-1:0];
    assign cnt       = (rem_small < left_small) ? rem_small : left_small;
    assign frame_end = rem_le4 && (rem_small <= left_small);
    assign left_next = frame_end ? '0 : r_left - RUN_W'(cnt);

    assign color    = r_in_range ? rdata : '0;
    assign out_free = !r_out_valid || o_result.ready;

    always_comb begin
        n_state      = r_state;
        n_left       = r_left;
        n_in_range   = r_in_range;
        n_pd         = r_pd;
        n_out_valid  = r_out_valid && !o_result.ready;
        n_pix        = r_pix;
        n_vcnt       = r_vcnt;
        n_run_done   = r_run_done;
        n_frame_done = r_frame_done;
        o_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.mode == MODE_PALETTE) begin
                        ram_we = 1'b1;
                    end else begin
                        ram_re     = 1'b1;
                        n_left     = i_cmd.run_len;
                        n_in_range = i_cmd.in_range;
                        n_state    = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    for (int k = 0; k < PIXELS_PER_RESULT; k++) begin
                        n_pix[k] = (CNT_W'(k) < cnt) ? color : '0;
                    end
                    n_vcnt       = cnt;
                    n_run_done   = (left_next == '0);
                    n_frame_done = frame_end;
                    n_left       = left_next;
                    n_pd         = frame_end ? '0 : r_pd + PD_W'(cnt);
                    if (left_next == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pd        <= n_pd;
            r_out_valid <= n_out_valid;
        end
        r_left       <= n_left;
        r_in_range   <= n_in_range;
        r_pix        <= n_pix;
        r_vcnt       <= n_vcnt;
        r_run_done   <= n_run_done;
        r_frame_done <= n_frame_done;
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.pixel_a     = r_pix[0];
    assign o_result.pixel_b     = r_pix[1];
    assign o_result.pixel_c     = r_pix[2];
    assign o_result.pixel_d     = r_pix[3];
    assign o_result.valid_count = r_vcnt;
    assign o_result.run_done    = r_run_done;
    assign o_result.frame_done  = r_frame_done;
endmodule

// File: design/palette_rle_frame_decoder.sv
`timescale 1ns / 1ps
// palette run-length frame decoder
// i_item carries either a palette write (mode 0: color_index, palette_color) or a
// run pair (mode 1: run_length, color_index; a run_length of 0 means 256 pixels)
// o_result carries up to four RGB pixels, valid_count, run_done and frame_done
// both channels use valid/ready; an item moves when both are high at a clock edge
// i_cfg_we / i_cfg_wdata load frame_pixels; write only while the block is idle
// the front stage registers and classifies items and pushes them into a 4-entry
// queue, so input keeps flowing while the back end expands a run
// the back end pops one command per idle cycle: a palette write is done at the pop,
// a run first reads the palette at the pop and then emits results of up to four
// pixels each, fewer results when the frame ends inside the run
// a run item passes front register, queue, palette RAM read and output register
// the back end is the rate limit: one result per cycle while the receiver is ready
// when the receiver stalls the single output register holds, the back end waits,
// and the queue then the front stage fill before i_item.ready drops
// synchronous reset clears the queue, the pixel counter and the output valid,
// and sets frame_pixels to 65536; palette contents are not cleared

module palette_rle_frame_decoder #(
    parameter int PALETTE_SIZE     = 256,
    parameter int MAX_FRAME_PIXELS = 4194304
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [prfd_pkg::CFG_W-1:0] i_cfg_wdata,
    prfd_in_if.sink                    i_item,
    prfd_out_if.source                 o_result
);
    import prfd_pkg::*;

    logic [CFG_W-1:0] r_frame_pixels;
    logic             push;
    logic             pop;
    t_cmd             push_cmd;
    t_cmd             head_cmd;
    t_q_stat          q_stat;

    // frame size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pixels <= FRAME_PIXELS_RESET;
        end else if (i_cfg_we) begin
            r_frame_pixels <= i_cfg_wdata;
        end
    end

    // front: accept and classify
    prfd_front #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_q_full (q_stat.full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // command queue between front and back
    prfd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    // back: palette memory, run expansion and frame counting
    prfd_back #(
        .PALETTE_SIZE     (PALETTE_SIZE),
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_pixels (r_frame_pixels),
        .i_cmd          (head_cmd),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .o_result       (o_result)
    );

    // a result always holds one to four pixels
    a_vcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.valid_count != 3'd0 && o_result.valid_count <= 3'd4))
        else $error("valid_count out of range");

    // the end of a frame drops the rest of the run
    a_frame_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.frame_done |-> o_result.run_done)
        else $error("frame_done without run_done");

    // unused pixel slots read as zero; the check covers pixel_d
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.valid_count < 3'd4 |-> o_result.pixel_d == '0)
        else $error("pixel_d nonzero beyond valid_count");

    // no pop from an empty queue, no push into a full one
    a_queue_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && q_stat.empty) && !(push && q_stat.full))
        else $error("queue overrun or underrun");
endmodule
